// ===== src/affine_voxel_source_address_defines.svh =====
// Assertion helpers for the asserting module.
// Both expect signals named clock and reset in scope.
`ifndef AFFINE_VOXEL_SOURCE_ADDRESS_DEFINES_SVH
`define AFFINE_VOXEL_SOURCE_ADDRESS_DEFINES_SVH

// Antecedent and consequent in the same cycle.
`define AVSA_ASSERT_NOW(name, ante, cons, msg) \
   name: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Consequent in the cycle after the antecedent.
`define AVSA_ASSERT_NEXT(name, ante, cons, msg) \
   name: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== src/avsa_pkg.sv =====
package avsa_pkg;

   localparam int COORD_BITS = 16;
   localparam int FRAC_BITS  = 16;

   localparam int FIELD_BITS    = 16;
   localparam int COEF_BITS     = 32;
   localparam int CSR_DATA_BITS = 64;
   localparam int CSR_INDEX_BITS = 3;
   localparam int DIMS_BITS     = 48;

   // signed coef times zero-extended coordinate, then three products plus offset
   localparam int PROD_BITS = COEF_BITS + COORD_BITS + 1;
   localparam int ACC_BITS  = PROD_BITS + 2;
   localparam int QUOT_BITS = ACC_BITS - FRAC_BITS;

   localparam logic [CSR_DATA_BITS-1:0] COEF_X_IJ_RESET = 64'h0000_0000_0001_0000;
   localparam logic [CSR_DATA_BITS-1:0] COEF_X_KT_RESET = 64'h0000_0000_0000_0000;
   localparam logic [CSR_DATA_BITS-1:0] COEF_Y_IJ_RESET = 64'h0001_0000_0000_0000;
   localparam logic [CSR_DATA_BITS-1:0] COEF_Y_KT_RESET = 64'h0000_0000_0000_0000;
   localparam logic [CSR_DATA_BITS-1:0] COEF_Z_IJ_RESET = 64'h0000_0000_0000_0000;
   localparam logic [CSR_DATA_BITS-1:0] COEF_Z_KT_RESET = 64'h0000_0000_0001_0000;
   localparam logic [DIMS_BITS-1:0]     VOLUME_DIMS_RESET = 48'h0100_0100_0100;

   typedef enum logic [CSR_INDEX_BITS-1:0] {
      CSR_COEF_X_IJ   = 3'd0,
      CSR_COEF_X_KT   = 3'd1,
      CSR_COEF_Y_IJ   = 3'd2,
      CSR_COEF_Y_KT   = 3'd3,
      CSR_COEF_Z_IJ   = 3'd4,
      CSR_COEF_Z_KT   = 3'd5,
      CSR_VOLUME_DIMS = 3'd6
   } csr_index_type;

   typedef struct packed {
      logic [FIELD_BITS-1:0] dest_x;
      logic [FIELD_BITS-1:0] dest_y;
      logic [FIELD_BITS-1:0] dest_z;
   } dest_type;

   typedef struct packed {
      logic [FIELD_BITS-1:0] source_x;
      logic [FIELD_BITS-1:0] source_y;
      logic [FIELD_BITS-1:0] source_z;
      logic                  in_range;
   } source_type;

   // one row of the transform: ij = {coef y, coef x}, kt = {offset, coef z}
   typedef struct packed {
      logic [CSR_DATA_BITS-1:0] ij;
      logic [CSR_DATA_BITS-1:0] kt;
   } coef_row_type;

   typedef struct packed {
      coef_row_type         row_x;
      coef_row_type         row_y;
      coef_row_type         row_z;
      logic [DIMS_BITS-1:0] volume_dims;
   } coef_set_type;

endpackage

// ===== src/avsa_csr.sv =====
module avsa_csr
   import avsa_pkg::*;
(
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      csr_write,
   input  logic [CSR_INDEX_BITS-1:0] csr_index,
   input  logic [CSR_DATA_BITS-1:0]  csr_wdata,
   output coef_set_type              coef
);

   logic [CSR_DATA_BITS-1:0] x_ij_ff, x_kt_ff, y_ij_ff, y_kt_ff, z_ij_ff, z_kt_ff;
   logic [CSR_DATA_BITS-1:0] x_ij_in, x_kt_in, y_ij_in, y_kt_in, z_ij_in, z_kt_in;
   logic [DIMS_BITS-1:0]     dims_ff, dims_in;

   always_comb begin
      x_ij_in = x_ij_ff;
      x_kt_in = x_kt_ff;
      y_ij_in = y_ij_ff;
      y_kt_in = y_kt_ff;
      z_ij_in = z_ij_ff;
      z_kt_in = z_kt_ff;
      dims_in = dims_ff;
      if (csr_write) begin
         unique case (csr_index_type'(csr_index))
            CSR_COEF_X_IJ:   x_ij_in = csr_wdata;
            CSR_COEF_X_KT:   x_kt_in = csr_wdata;
            CSR_COEF_Y_IJ:   y_ij_in = csr_wdata;
            CSR_COEF_Y_KT:   y_kt_in = csr_wdata;
            CSR_COEF_Z_IJ:   z_ij_in = csr_wdata;
            CSR_COEF_Z_KT:   z_kt_in = csr_wdata;
            CSR_VOLUME_DIMS: dims_in = csr_wdata[DIMS_BITS-1:0];
            default:         ; // unmapped index: dropped
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         x_ij_ff <= COEF_X_IJ_RESET;
         x_kt_ff <= COEF_X_KT_RESET;
         y_ij_ff <= COEF_Y_IJ_RESET;
         y_kt_ff <= COEF_Y_KT_RESET;
         z_ij_ff <= COEF_Z_IJ_RESET;
         z_kt_ff <= COEF_Z_KT_RESET;
         dims_ff <= VOLUME_DIMS_RESET;
      end else begin
         x_ij_ff <= x_ij_in;
         x_kt_ff <= x_kt_in;
         y_ij_ff <= y_ij_in;
         y_kt_ff <= y_kt_in;
         z_ij_ff <= z_ij_in;
         z_kt_ff <= z_kt_in;
         dims_ff <= dims_in;
      end
   end

   assign coef.row_x       = '{ij: x_ij_ff, kt: x_kt_ff};
   assign coef.row_y       = '{ij: y_ij_ff, kt: y_kt_ff};
   assign coef.row_z       = '{ij: z_ij_ff, kt: z_kt_ff};
   assign coef.volume_dims = dims_ff;

endmodule

// ===== src/avsa_axis.sv =====
module avsa_axis
   import avsa_pkg::*;
(
   input  coef_row_type          row,
   input  logic [FIELD_BITS-1:0] dim,
   input  logic [COORD_BITS-1:0] x,
   input  logic [COORD_BITS-1:0] y,
   input  logic [COORD_BITS-1:0] z,
   output logic [FIELD_BITS-1:0] coord,
   output logic                  ok
);

   logic signed [COEF_BITS-1:0]  ca, cb, cc, ct;
   logic signed [COORD_BITS:0]   sx, sy, sz;
   logic signed [PROD_BITS-1:0]  pa, pb, pc;
   logic signed [ACC_BITS-1:0]   acc;
   logic        [QUOT_BITS-1:0]  quot;
   logic                         pos_ok, neg_ok;

   assign ca = signed'(row.ij[COEF_BITS-1:0]);
   assign cb = signed'(row.ij[2*COEF_BITS-1:COEF_BITS]);
   assign cc = signed'(row.kt[COEF_BITS-1:0]);
   assign ct = signed'(row.kt[2*COEF_BITS-1:COEF_BITS]);

   assign sx = signed'({1'b0, x});
   assign sy = signed'({1'b0, y});
   assign sz = signed'({1'b0, z});

   assign pa = PROD_BITS'(ca) * PROD_BITS'(sx);
   assign pb = PROD_BITS'(cb) * PROD_BITS'(sy);
   assign pc = PROD_BITS'(cc) * PROD_BITS'(sz);

   assign acc = ACC_BITS'(pa) + ACC_BITS'(pb) + ACC_BITS'(pc) + ACC_BITS'(ct);

   assign quot = acc[ACC_BITS-1:FRAC_BITS];

   // truncation toward zero: a sum in (-1, 0) lands on zero
   assign neg_ok = (&acc[ACC_BITS-1:FRAC_BITS]) && (|acc[FRAC_BITS-1:0]) && (dim != '0);
   assign pos_ok = !acc[ACC_BITS-1] && (quot < QUOT_BITS'(dim));

   assign ok    = pos_ok || neg_ok;
   assign coord = pos_ok ? quot[FIELD_BITS-1:0] : '0;

endmodule

// ===== src/affine_voxel_source_address.sv =====
// Channel    | ports                                  | beat
// -----------+----------------------------------------+---------------------------------
// request    | start, busy, req_data (dest_type)      | start high while busy low
// response   | rsp_valid, rsp_data (source_type)      | rsp_valid high, one cycle only
// csr        | csr_write, csr_index, csr_wdata        | csr_write high, no wait
//
// One request beat per cycle, sustained while busy is low; a response beat follows its
// request beat through the request register, then the response register.
// The path between them is three 32x17 multipliers per axis and one wide add.
// Synchronous reset: busy holds high through reset and into the cycle after it.
// The response side cannot stall, so busy never rises once out of reset.
`include "affine_voxel_source_address_defines.svh"

module affine_voxel_source_address
   import avsa_pkg::*;
(
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      start,
   output logic                      busy,
   input  dest_type                  req_data,
   output logic                      rsp_valid,
   output source_type                rsp_data,
   input  logic                      csr_write,
   input  logic [CSR_INDEX_BITS-1:0] csr_index,
   input  logic [CSR_DATA_BITS-1:0]  csr_wdata
);

   coef_set_type coef;

   // request register
   logic       req_valid_ff, req_valid_in;
   dest_type   dest_ff, dest_in;
   logic       busy_ff;

   // response register
   logic       rsp_valid_ff, rsp_valid_in;
   source_type rsp_data_ff, rsp_data_in;

   logic [FIELD_BITS-1:0] coord_x, coord_y, coord_z;
   logic                  ok_x, ok_y, ok_z;
   logic                  accept;

   avsa_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_write (csr_write),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .coef      (coef)
   );

   assign accept = start && !busy_ff;

   always_comb begin
      req_valid_in = accept;
      dest_in      = accept ? req_data : dest_ff;
   end

   // Only the low COORD_BITS of each destination coordinate enter the map.
   avsa_axis u_axis_x (
      .row   (coef.row_x),
      .dim   (coef.volume_dims[FIELD_BITS-1:0]),
      .x     (dest_ff.dest_x[COORD_BITS-1:0]),
      .y     (dest_ff.dest_y[COORD_BITS-1:0]),
      .z     (dest_ff.dest_z[COORD_BITS-1:0]),
      .coord (coord_x),
      .ok    (ok_x)
   );

   avsa_axis u_axis_y (
      .row   (coef.row_y),
      .dim   (coef.volume_dims[2*FIELD_BITS-1:FIELD_BITS]),
      .x     (dest_ff.dest_x[COORD_BITS-1:0]),
      .y     (dest_ff.dest_y[COORD_BITS-1:0]),
      .z     (dest_ff.dest_z[COORD_BITS-1:0]),
      .coord (coord_y),
      .ok    (ok_y)
   );

   avsa_axis u_axis_z (
      .row   (coef.row_z),
      .dim   (coef.volume_dims[3*FIELD_BITS-1:2*FIELD_BITS]),
      .x     (dest_ff.dest_x[COORD_BITS-1:0]),
      .y     (dest_ff.dest_y[COORD_BITS-1:0]),
      .z     (dest_ff.dest_z[COORD_BITS-1:0]),
      .coord (coord_z),
      .ok    (ok_z)
   );

   // Any axis out of the volume zeroes the whole beat.
   always_comb begin
      rsp_valid_in = req_valid_ff;
      rsp_data_in  = rsp_data_ff;
      if (req_valid_ff) begin
         if (ok_x && ok_y && ok_z) begin
            rsp_data_in = '{source_x: coord_x, source_y: coord_y,
                            source_z: coord_z, in_range: 1'b1};
         end else begin
            rsp_data_in = '0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff      <= 1'b1;
         req_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         busy_ff      <= 1'b0;
         req_valid_ff <= req_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      dest_ff     <= dest_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign busy      = busy_ff;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // every request beat yields exactly one response beat, via the request and response registers
   `AVSA_ASSERT_NOW(a_rsp_follows_req, 1'b1, rsp_valid == $past(accept, 2), "response beat count off")
   // an out-of-range beat carries a zero coordinate
   `AVSA_ASSERT_NOW(a_oor_zero, rsp_valid && !rsp_data.in_range, (rsp_data.source_x == '0) && (rsp_data.source_y == '0) && (rsp_data.source_z == '0), "out-of-range beat not zeroed")
   // once out of reset the block never refuses a request
   `AVSA_ASSERT_NEXT(a_busy_stays_low, !busy, !busy, "busy rose after reset")

endmodule
